### rtl/brn_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brn_pkg: shared definitions of the bilinear resize and normalize block
// Sizes, configuration register indexes, reset values, controller states and
// the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package brn_pkg;

    localparam int OUT_WIDTH        = 480;
    localparam int OUT_HEIGHT       = 480;
    localparam int MAX_SOURCE_WIDTH = 4096;
    localparam int FRACTION_BITS    = 16;
    localparam int MAX_RESULTS      = 64;

    localparam int COORD_W    = 9;
    localparam int SRC_W      = $clog2(MAX_SOURCE_WIDTH);
    localparam int SIZE_W     = 13;
    localparam int CNT_W      = $clog2(MAX_RESULTS);
    localparam int PIX_W      = 8;
    localparam int RGB_W      = 3 * PIX_W;
    localparam int GAIN_W     = 24;
    localparam int OFFS_W     = 16;
    localparam int NORM_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Both output sizes are 480, so the mapping divides by 2*480 = 64*15.
    // The power of two folds into the shift; the 15 is a reciprocal multiply
    // that is exact for any 32-bit dividend.
    localparam logic [31:0] DIV15_MAGIC = 32'h8888_8889;
    localparam int          DIV15_SHIFT = 35;

    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_RED      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_GREEN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_BLUE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_RED    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_GREEN  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BLUE   = 3'd7;

    localparam logic [SIZE_W-1:0]        RST_SOURCE_WIDTH  = 13'd480;
    localparam logic [SIZE_W-1:0]        RST_SOURCE_HEIGHT = 13'd480;
    localparam logic [GAIN_W-1:0]        RST_GAIN_RED      = 24'd287306;
    localparam logic [GAIN_W-1:0]        RST_GAIN_GREEN    = 24'd293719;
    localparam logic [GAIN_W-1:0]        RST_GAIN_BLUE     = 24'd292413;
    localparam logic signed [OFFS_W-1:0] RST_OFFSET_RED    = -16'sd8675;
    localparam logic signed [OFFS_W-1:0] RST_OFFSET_GREEN  = -16'sd8338;
    localparam logic signed [OFFS_W-1:0] RST_OFFSET_BLUE   = -16'sd7391;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ROW_REQ,
        S_ROW_WAIT,
        S_COL_REQ,
        S_COL_WAIT,
        S_OUT_INIT,
        S_Y_REQ,
        S_Y_WAIT,
        S_X_REQ,
        S_X_WAIT,
        S_RD_X0,
        S_RD_X1,
        S_RD_CAP,
        S_CALC_H,
        S_CALC_V,
        S_CALC_G,
        S_EMIT,
        S_FINISH
    } t_state;

    typedef enum logic [1:0] {
        MAP_ROW_SCAN,
        MAP_COL_SCAN,
        MAP_OUT_Y,
        MAP_OUT_X
    } t_map_sel;

    typedef struct packed {
        logic     accept;
        logic     map_go;
        t_map_sel map_sel;
        logic     row_take;
        logic     col_take;
        logic     out_init;
        logic     y_latch;
        logic     x_latch;
        logic     rd_x1;
        logic     cap_left;
        logic     cap_right;
        logic     emit;
        logic     finish;
    } t_dp_cmd;

    typedef struct packed {
        logic col_zero;
        logic y_scan_done;
        logic x_scan_done;
        logic map_done;
        logic map_hit_row;
        logic map_hit_col;
        logic out_any;
        logic run_end;
        logic out_last;
        logic out_free;
    } t_dp_sts;

endpackage
`default_nettype wire

### rtl/brn_pixel_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brn_pixel_if: source pixel channel
// Valid/ready channel that carries one RGB source pixel per transaction.
// ----------------------------------------------------------------------------
interface brn_pixel_if import brn_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface
`default_nettype wire

### rtl/brn_result_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brn_result_if: scaled and normalized output channel
// Valid/ready channel that carries one output pixel per transaction.
// ----------------------------------------------------------------------------
interface brn_result_if import brn_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [COORD_W-1:0]       out_x;
    logic [COORD_W-1:0]       out_y;
    logic signed [NORM_W-1:0] norm_red;
    logic signed [NORM_W-1:0] norm_green;
    logic signed [NORM_W-1:0] norm_blue;
    logic                     run_last;
    logic                     frame_end;

    modport source (output valid, out_x, out_y, norm_red, norm_green, norm_blue,
                    run_last, frame_end, input ready);
    modport sink   (input valid, out_x, out_y, norm_red, norm_green, norm_blue,
                    run_last, frame_end, output ready);
endinterface
`default_nettype wire

### rtl/brn_coord_map.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brn_coord_map: output to source coordinate mapper
// Three-stage unit: q = floor((2i+1) * n * 2^F / 960) - 2^(F-1), then split
// into the left source index, the right source index and the weight, with
// clamping at both edges. o_done pulses when the outputs are valid; they hold
// until the next request.
// ----------------------------------------------------------------------------
module brn_coord_map import brn_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_go,
    input  logic [COORD_W-1:0]       i_idx,
    input  logic [SIZE_W-1:0]        i_size,
    output logic                     o_done,
    output logic [SRC_W-1:0]         o_i0,
    output logic [SRC_W-1:0]         o_i1,
    output logic [FRACTION_BITS-1:0] o_w
);

    localparam int NUM_W = COORD_W + 1 + SIZE_W;
    localparam int QUO_W = 64 - DIV15_SHIFT;
    localparam logic [QUO_W-1:0] HALF = QUO_W'(1) << (FRACTION_BITS - 1);

    logic                     r_v1, r_v2, r_done;
    logic [NUM_W-1:0]         r_num;
    logic [SRC_W-1:0]         r_nm1_1, r_nm1_2;
    logic [QUO_W-1:0]         r_quo;
    logic [SRC_W-1:0]         r_i0, r_i1;
    logic [FRACTION_BITS-1:0] r_w;

    logic [SIZE_W-1:0]        size_m1;
    logic [31:0]              dividend;
    logic [63:0]              quo_full;
    logic [QUO_W-1:0]         shifted;
    logic [QUO_W-FRACTION_BITS-1:0] idx_a;
    logic [FRACTION_BITS-1:0] wt;
    logic [SRC_W-1:0]         n_i0, n_i1;

    assign size_m1  = i_size - SIZE_W'(1);
    // (2i+1)*n stays below 2^22, so shifting by ten keeps it in 32 bits.
    assign dividend = {r_num[21:0], 10'b0};
    assign quo_full = {32'b0, dividend} * {32'b0, DIV15_MAGIC};

    always_comb begin
        shifted = (r_quo >= HALF) ? (r_quo - HALF) : '0;
        idx_a   = shifted[QUO_W-1:FRACTION_BITS];
        wt      = shifted[FRACTION_BITS-1:0];
        if (idx_a > {1'b0, r_nm1_2}) begin
            idx_a = {1'b0, r_nm1_2};
            wt    = '0;
        end
        n_i0 = idx_a[SRC_W-1:0];
        n_i1 = (n_i0 == r_nm1_2) ? r_nm1_2 : n_i0 + SRC_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v1   <= i_go;
            r_v2   <= r_v1;
            r_done <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_num   <= {i_idx, 1'b1} * i_size;
            r_nm1_1 <= size_m1[SRC_W-1:0];
        end
        if (r_v1) begin
            r_quo   <= quo_full[63:DIV15_SHIFT];
            r_nm1_2 <= r_nm1_1;
        end
        if (r_v2) begin
            r_i0 <= n_i0;
            r_i1 <= n_i1;
            r_w  <= wt;
        end
    end

    assign o_done = r_done;
    assign o_i0   = r_i0;
    assign o_i1   = r_i1;
    assign o_w    = r_w;

endmodule
`default_nettype wire

### rtl/brn_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brn_datapath: line stores, counters, interpolation and normalization
// Holds the configuration, two ping-pong line stores (the current source row
// and the one before), the frame and output counters, the coordinate mapper,
// the three-stage blend and gain pipeline and the output register.
// ----------------------------------------------------------------------------
module brn_datapath import brn_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [PIX_W-1:0]      i_red,
    input  logic [PIX_W-1:0]      i_green,
    input  logic [PIX_W-1:0]      i_blue,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    brn_result_if.source          o_res
);

    localparam int HSUM_W = 2 * PIX_W + FRACTION_BITS;
    localparam int PROD_W = 2 * PIX_W + GAIN_W;

    // Horizontal blend of two bytes: a*2^F + (b-a)*w.
    function automatic logic [RGB_W-1:0] lerp_pix(logic [PIX_W-1:0] a,
                                                  logic [PIX_W-1:0] b,
                                                  logic [FRACTION_BITS-1:0] w);
        logic signed [PIX_W:0]  d;
        logic signed [HSUM_W:0] s;
        d = $signed({1'b0, b}) - $signed({1'b0, a});
        s = $signed({1'b0, a, {FRACTION_BITS{1'b0}}}) + d * $signed({1'b0, w});
        return s[RGB_W-1:0];
    endfunction

    // Vertical blend, rounded half up to eight fraction bits.
    function automatic logic [2*PIX_W-1:0] lerp_row(logic [RGB_W-1:0] a,
                                                    logic [RGB_W-1:0] b,
                                                    logic [FRACTION_BITS-1:0] w);
        logic signed [RGB_W:0]                 d;
        logic signed [RGB_W+FRACTION_BITS+1:0] s;
        logic [RGB_W+FRACTION_BITS-1:0]        r;
        d = $signed({1'b0, b}) - $signed({1'b0, a});
        s = $signed({2'b0, a, {FRACTION_BITS{1'b0}}}) + d * $signed({1'b0, w});
        r = s[RGB_W+FRACTION_BITS-1:0]
            + ((RGB_W+FRACTION_BITS)'(1) << (2 * FRACTION_BITS - 9));
        return r[RGB_W+FRACTION_BITS-1:2*FRACTION_BITS-8];
    endfunction

    function automatic logic [SIZE_W-1:0] clamp_size(logic [SIZE_W-1:0] v);
        if (v == '0) begin
            return SIZE_W'(1);
        end else if (v > SIZE_W'(MAX_SOURCE_WIDTH)) begin
            return SIZE_W'(MAX_SOURCE_WIDTH);
        end
        return v;
    endfunction

    // Configuration.
    logic [SIZE_W-1:0]        r_src_w, r_src_h;
    logic [GAIN_W-1:0]        r_gain [3];
    logic signed [OFFS_W-1:0] r_offs [3];

    // Frame and output counters.
    logic [SRC_W-1:0]   r_col, r_row;
    logic               r_bank;
    logic [COORD_W-1:0] r_x_ptr, r_x_end, r_y_ptr;
    logic [COORD_W-1:0] r_first_y, r_last_y, r_cur_x, r_cur_y;
    logic               r_pending;
    logic [CNT_W-1:0]   r_count;

    // Per-output coordinates and data.
    logic [FRACTION_BITS-1:0] r_wy, r_wx;
    logic                     r_top_lower;
    logic [SRC_W-1:0]         r_x0, r_x1;
    logic [RGB_W-1:0]         r_line0 [MAX_SOURCE_WIDTH];
    logic [RGB_W-1:0]         r_line1 [MAX_SOURCE_WIDTH];
    logic [RGB_W-1:0]         r_rd0, r_rd1;
    logic [RGB_W-1:0]         r_left_top, r_left_bot, r_right_top, r_right_bot;
    logic [RGB_W-1:0]         r_h_top [3];
    logic [RGB_W-1:0]         r_h_bot [3];
    logic [2*PIX_W-1:0]       r_p [3];
    logic [PROD_W-1:0]        r_prod [3];

    // Output register.
    logic                     r_o_valid;
    logic [COORD_W-1:0]       r_o_x, r_o_y;
    logic signed [NORM_W-1:0] r_o_norm [3];
    logic                     r_o_last, r_o_fend;

    logic                     size_wr, wr_bank, run_end, out_last, out_free;
    logic [SRC_W-1:0]         rd_addr;
    logic [RGB_W-1:0]         pix, lower_rd, upper_rd;
    logic [COORD_W-1:0]       map_idx;
    logic [SIZE_W-1:0]        map_size;
    logic                     map_done;
    logic [SRC_W-1:0]         map_i0, map_i1;
    logic [FRACTION_BITS-1:0] map_w;
    logic signed [NORM_W-1:0] norm [3];
    logic [PROD_W-1:0]        rnd_sum [3];
    logic signed [21:0]       biased [3];

    assign pix      = {i_red, i_green, i_blue};
    assign size_wr  = i_cfg_we && (i_cfg_idx == CFG_SOURCE_WIDTH
                                   || i_cfg_idx == CFG_SOURCE_HEIGHT);
    // A new source row goes into the bank that held the row before last.
    assign wr_bank  = (r_col == '0) ? ~r_bank : r_bank;
    assign rd_addr  = i_cmd.rd_x1 ? r_x1 : r_x0;
    assign lower_rd = r_bank ? r_rd1 : r_rd0;
    assign upper_rd = r_bank ? r_rd0 : r_rd1;
    assign run_end  = (r_cur_x == r_x_end - COORD_W'(1));
    assign out_last = (r_count == CNT_W'(MAX_RESULTS - 1)) || (run_end && r_cur_y == r_last_y);
    assign out_free = !r_o_valid || o_res.ready;

    always_comb begin
        unique case (i_cmd.map_sel)
            MAP_ROW_SCAN: begin
                map_idx  = r_y_ptr;
                map_size = r_src_h;
            end
            MAP_COL_SCAN: begin
                map_idx  = r_x_end;
                map_size = r_src_w;
            end
            MAP_OUT_Y: begin
                map_idx  = r_cur_y;
                map_size = r_src_h;
            end
            MAP_OUT_X: begin
                map_idx  = r_cur_x;
                map_size = r_src_w;
            end
            default: begin
                map_idx  = r_cur_x;
                map_size = r_src_w;
            end
        endcase
    end

    brn_coord_map u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_cmd.map_go),
        .i_idx   (map_idx),
        .i_size  (map_size),
        .o_done  (map_done),
        .o_i0    (map_i0),
        .o_i1    (map_i1),
        .o_w     (map_w)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w   <= RST_SOURCE_WIDTH;
            r_src_h   <= RST_SOURCE_HEIGHT;
            r_gain[0] <= RST_GAIN_RED;
            r_gain[1] <= RST_GAIN_GREEN;
            r_gain[2] <= RST_GAIN_BLUE;
            r_offs[0] <= RST_OFFSET_RED;
            r_offs[1] <= RST_OFFSET_GREEN;
            r_offs[2] <= RST_OFFSET_BLUE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SOURCE_WIDTH:  r_src_w   <= clamp_size(i_cfg_data[SIZE_W-1:0]);
                CFG_SOURCE_HEIGHT: r_src_h   <= clamp_size(i_cfg_data[SIZE_W-1:0]);
                CFG_GAIN_RED:      r_gain[0] <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_GREEN:    r_gain[1] <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_BLUE:     r_gain[2] <= i_cfg_data[GAIN_W-1:0];
                CFG_OFFSET_RED:    r_offs[0] <= $signed(i_cfg_data[OFFS_W-1:0]);
                CFG_OFFSET_GREEN:  r_offs[1] <= $signed(i_cfg_data[OFFS_W-1:0]);
                CFG_OFFSET_BLUE:   r_offs[2] <= $signed(i_cfg_data[OFFS_W-1:0]);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || size_wr) begin
            r_col     <= '0;
            r_row     <= '0;
            r_bank    <= 1'b0;
            r_x_ptr   <= '0;
            r_x_end   <= '0;
            r_y_ptr   <= '0;
            r_first_y <= '0;
            r_last_y  <= '0;
            r_cur_x   <= '0;
            r_cur_y   <= '0;
            r_pending <= 1'b0;
            r_count   <= '0;
        end else begin
            if (i_cmd.accept && r_col == '0) begin
                r_bank    <= ~r_bank;
                r_x_ptr   <= '0;
                r_x_end   <= '0;
                r_pending <= 1'b0;
                if (r_row == '0) begin
                    r_y_ptr <= '0;
                end
            end
            if (i_cmd.row_take) begin
                if (!r_pending) begin
                    r_first_y <= r_y_ptr;
                end
                r_last_y  <= r_y_ptr;
                r_pending <= 1'b1;
                r_y_ptr   <= r_y_ptr + COORD_W'(1);
            end
            if (i_cmd.col_take) begin
                r_x_end <= r_x_end + COORD_W'(1);
            end
            if (i_cmd.out_init) begin
                r_cur_y <= r_first_y;
                r_cur_x <= r_x_ptr;
                r_count <= '0;
            end
            if (i_cmd.emit) begin
                r_count <= r_count + CNT_W'(1);
                if (run_end) begin
                    r_cur_y <= r_cur_y + COORD_W'(1);
                    r_cur_x <= r_x_ptr;
                end else begin
                    r_cur_x <= r_cur_x + COORD_W'(1);
                end
            end
            if (i_cmd.finish) begin
                r_x_ptr <= r_x_end;
                if ({1'b0, r_col} + SIZE_W'(1) == r_src_w) begin
                    r_col <= '0;
                    if ({1'b0, r_row} + SIZE_W'(1) == r_src_h) begin
                        r_row <= '0;
                    end else begin
                        r_row <= r_row + SRC_W'(1);
                    end
                end else begin
                    r_col <= r_col + SRC_W'(1);
                end
            end
        end
    end

    // Line stores: one write port for the incoming pixel, one read port each.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && !wr_bank) begin
            r_line0[r_col] <= pix;
        end
        if (i_cmd.accept && wr_bank) begin
            r_line1[r_col] <= pix;
        end
        r_rd0 <= r_line0[rd_addr];
        r_rd1 <= r_line1[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.y_latch) begin
            r_wy        <= map_w;
            r_top_lower <= (map_i0 == r_row);
        end
        if (i_cmd.x_latch) begin
            r_x0 <= map_i0;
            r_x1 <= map_i1;
            r_wx <= map_w;
        end
        if (i_cmd.cap_left) begin
            r_left_top <= r_top_lower ? lower_rd : upper_rd;
            r_left_bot <= lower_rd;
        end
        if (i_cmd.cap_right) begin
            r_right_top <= r_top_lower ? lower_rd : upper_rd;
            r_right_bot <= lower_rd;
        end
        for (int c = 0; c < 3; c++) begin
            r_h_top[c] <= lerp_pix(r_left_top[PIX_W*(2-c) +: PIX_W],
                                   r_right_top[PIX_W*(2-c) +: PIX_W], r_wx);
            r_h_bot[c] <= lerp_pix(r_left_bot[PIX_W*(2-c) +: PIX_W],
                                   r_right_bot[PIX_W*(2-c) +: PIX_W], r_wx);
            r_p[c]     <= lerp_row(r_h_top[c], r_h_bot[c], r_wy);
            r_prod[c]  <= r_p[c] * r_gain[c];
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            rnd_sum[c] = r_prod[c] + PROD_W'(1 << 19);
            biased[c]  = $signed({2'b0, rnd_sum[c][PROD_W-1:20]}) + 22'(r_offs[c]);
            if (biased[c] > 22'sd32767) begin
                norm[c] = 16'sh7fff;
            end else if (biased[c] < -22'sd32768) begin
                norm[c] = -16'sh8000;
            end else begin
                norm[c] = biased[c][NORM_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_o_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_x    <= r_cur_x;
            r_o_y    <= r_cur_y;
            r_o_norm <= norm;
            r_o_last <= out_last;
            r_o_fend <= (r_cur_x == COORD_W'(OUT_WIDTH - 1))
                        && (r_cur_y == COORD_W'(OUT_HEIGHT - 1));
        end
    end

    assign o_res.valid      = r_o_valid;
    assign o_res.out_x      = r_o_x;
    assign o_res.out_y      = r_o_y;
    assign o_res.norm_red   = r_o_norm[0];
    assign o_res.norm_green = r_o_norm[1];
    assign o_res.norm_blue  = r_o_norm[2];
    assign o_res.run_last   = r_o_last;
    assign o_res.frame_end  = r_o_fend;

    assign o_sts.col_zero    = (r_col == '0);
    assign o_sts.y_scan_done = (r_y_ptr == COORD_W'(OUT_HEIGHT));
    assign o_sts.x_scan_done = (r_x_end == COORD_W'(OUT_WIDTH));
    assign o_sts.map_done    = map_done;
    assign o_sts.map_hit_row = (map_i1 == r_row);
    assign o_sts.map_hit_col = (map_i1 == r_col);
    assign o_sts.out_any     = r_pending && (r_x_ptr != r_x_end);
    assign o_sts.run_end     = run_end;
    assign o_sts.out_last    = out_last;
    assign o_sts.out_free    = out_free;

endmodule
`default_nettype wire

### rtl/brn_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brn_ctrl: sequencer of the bilinear resize and normalize block
// Per source pixel: store it, find the output rows (on the first column) and
// columns it completes, then walk the released outputs one at a time through
// mapping, line store reads and the arithmetic stages.
// ----------------------------------------------------------------------------
module brn_ctrl import brn_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = i_sts.col_zero ? S_ROW_REQ : S_COL_REQ;
                end
            end
            S_ROW_REQ: begin
                if (i_sts.y_scan_done) begin
                    n_state = S_COL_REQ;
                end else begin
                    o_cmd.map_go  = 1'b1;
                    o_cmd.map_sel = MAP_ROW_SCAN;
                    n_state = S_ROW_WAIT;
                end
            end
            S_ROW_WAIT: begin
                if (i_sts.map_done) begin
                    if (i_sts.map_hit_row) begin
                        o_cmd.row_take = 1'b1;
                        n_state = S_ROW_REQ;
                    end else begin
                        n_state = S_COL_REQ;
                    end
                end
            end
            S_COL_REQ: begin
                if (i_sts.x_scan_done) begin
                    n_state = S_OUT_INIT;
                end else begin
                    o_cmd.map_go  = 1'b1;
                    o_cmd.map_sel = MAP_COL_SCAN;
                    n_state = S_COL_WAIT;
                end
            end
            S_COL_WAIT: begin
                if (i_sts.map_done) begin
                    if (i_sts.map_hit_col) begin
                        o_cmd.col_take = 1'b1;
                        n_state = S_COL_REQ;
                    end else begin
                        n_state = S_OUT_INIT;
                    end
                end
            end
            S_OUT_INIT: begin
                if (i_sts.out_any) begin
                    o_cmd.out_init = 1'b1;
                    n_state = S_Y_REQ;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_Y_REQ: begin
                o_cmd.map_go  = 1'b1;
                o_cmd.map_sel = MAP_OUT_Y;
                n_state = S_Y_WAIT;
            end
            S_Y_WAIT: begin
                if (i_sts.map_done) begin
                    o_cmd.y_latch = 1'b1;
                    n_state = S_X_REQ;
                end
            end
            S_X_REQ: begin
                o_cmd.map_go  = 1'b1;
                o_cmd.map_sel = MAP_OUT_X;
                n_state = S_X_WAIT;
            end
            S_X_WAIT: begin
                if (i_sts.map_done) begin
                    o_cmd.x_latch = 1'b1;
                    n_state = S_RD_X0;
                end
            end
            S_RD_X0: begin
                n_state = S_RD_X1;
            end
            S_RD_X1: begin
                // Left-hand data is back while the right-hand read goes out.
                o_cmd.rd_x1    = 1'b1;
                o_cmd.cap_left = 1'b1;
                n_state = S_RD_CAP;
            end
            S_RD_CAP: begin
                o_cmd.cap_right = 1'b1;
                n_state = S_CALC_H;
            end
            S_CALC_H: begin
                n_state = S_CALC_V;
            end
            S_CALC_V: begin
                n_state = S_CALC_G;
            end
            S_CALC_G: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.out_last) begin
                        n_state = S_FINISH;
                    end else if (i_sts.run_end) begin
                        n_state = S_Y_REQ;
                    end else begin
                        n_state = S_X_REQ;
                    end
                end
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

### rtl/bilinear_resize_normalize.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bilinear_resize_normalize: streaming bilinear scaler with normalization
// Scales a raster RGB stream to 480x480 with half-pixel-centered bilinear
// interpolation and gives each output pixel as value * gain + offset in Q4.12.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake       Contents
//  i_pix     in   valid/ready     red, green, blue source pixel
//  o_res     out  valid/ready     out_x, out_y, norm_*, run_last, frame_end
//  i_cfg_*   in   write enable    register index and write data
//
//  A pixel that releases nothing is accepted, makes one coordinate mapper
//  round trip that misses, checks for outputs and advances the counters.
//  Each released output column adds a mapper round trip; the first pixel
//  of a row adds one per released output row and one for its own miss. A
//  scan that reaches the grid edge skips its miss. Each released output
//  then takes a column mapping, line store reads and arithmetic stages,
//  plus a row mapping at the start of each output row. The 3-stage mapper
//  is shared. Reset is synchronous and needs no clearing pass. A stalled
//  output register holds the sequencer only when it has the next result
//  ready; a new pixel is taken while the last one waits.
// ----------------------------------------------------------------------------
module bilinear_resize_normalize import brn_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    brn_pixel_if.sink             i_pix,
    brn_result_if.source          o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    in_ready;

    assign i_pix.ready = in_ready;

    brn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pix.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    brn_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_red      (i_pix.red),
        .i_green    (i_pix.green),
        .i_blue     (i_pix.blue),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_res      (o_res)
    );

`ifndef SYNTHESIS
    // The bottom-right output is the last of its run, since runs go in raster order.
    a_frame_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.frame_end) |-> o_res.run_last)
        else $error("frame end output not marked as last of its run");

    a_coord_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.out_x < COORD_W'(OUT_WIDTH)
                         && o_res.out_y < COORD_W'(OUT_HEIGHT)))
        else $error("output coordinate outside the scaled grid");

    a_one_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix.valid && i_pix.ready) |=> !i_pix.ready)
        else $error("second pixel taken before the first was processed");
`endif

endmodule
`default_nettype wire

### tb/brn_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brn_checker: scoreboard of the bilinear resize and normalize block
// Watches the pixel, result and register channels, works out the output
// pixels that each accepted source pixel releases and compares every result
// transaction field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module brn_checker import brn_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    brn_pixel_if                  i_pix,
    brn_result_if                 i_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    typedef struct packed {
        logic [COORD_W-1:0]       x;
        logic [COORD_W-1:0]       y;
        logic signed [NORM_W-1:0] red;
        logic signed [NORM_W-1:0] green;
        logic signed [NORM_W-1:0] blue;
        logic                     run_last;
        logic                     frame_end;
    } t_out_pixel;

    t_out_pixel      scaled_q[$];
    logic [RGB_W-1:0] line_above [MAX_SOURCE_WIDTH];
    logic [RGB_W-1:0] line_now   [MAX_SOURCE_WIDTH];
    int unsigned     width_reg, height_reg;
    int unsigned     gain_reg [3];
    int              offset_reg [3];
    int unsigned     src_col, src_row, out_col_next, row_first, row_last;
    bit              rows_open;

    function automatic int unsigned fit_size(int unsigned v);
        if (v == 0) return 1;
        if (v > MAX_SOURCE_WIDTH) return MAX_SOURCE_WIDTH;
        return v;
    endfunction

    // Half-pixel-centered source position of output index i, split into the
    // two neighbor indexes and the weight of the second one.
    function automatic void map_coord(input int unsigned i, n, m,
                                      output int unsigned i0, i1, wt);
        longint unsigned num, q, s, a, f;
        num = (longint'(2 * i + 1) * n) << FRACTION_BITS;
        q   = num / (2 * m);
        a   = 0;
        f   = 0;
        if (q >= (64'd1 << (FRACTION_BITS - 1))) begin
            s = q - (64'd1 << (FRACTION_BITS - 1));
            a = s >> FRACTION_BITS;
            f = s & ((64'd1 << FRACTION_BITS) - 1);
        end
        if (a > n - 1) begin
            a = n - 1;
            f = 0;
        end
        i0 = a;
        i1 = (a + 1 > n - 1) ? n - 1 : a + 1;
        wt = f;
    endfunction

    function automatic logic signed [NORM_W-1:0] norm_channel(
        input int unsigned tl, tr, bl, br, wx, wy, input int ch);
        longint unsigned one, top, bot, v, p, prod;
        longint          r;
        one  = 64'd1 << FRACTION_BITS;
        top  = 64'(tl) * (one - wx) + 64'(tr) * wx;
        bot  = 64'(bl) * (one - wx) + 64'(br) * wx;
        v    = top * (one - wy) + bot * wy;
        p    = (v + (64'd1 << (2 * FRACTION_BITS - 9))) >> (2 * FRACTION_BITS - 8);
        prod = p * gain_reg[ch];
        r    = longint'((prod + (64'd1 << 19)) >> 20) + offset_reg[ch];
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[NORM_W-1:0];
    endfunction

    function automatic logic [PIX_W-1:0] chan_of(logic [RGB_W-1:0] px, int ch);
        return px[RGB_W-1-PIX_W*ch -: PIX_W];
    endfunction

    function automatic void restart_frame();
        src_col      = 0;
        src_row      = 0;
        out_col_next = 0;
        row_first    = 0;
        row_last     = 0;
        rows_open    = 0;
    endfunction

    // Appends every output pixel released by one source pixel, capped at
    // MAX_RESULTS, and advances the raster counters.
    function automatic void release_outputs(logic [RGB_W-1:0] px);
        int unsigned w, h, col, row, x_end, a0, a1, wt, y0, y1, wy, x0, x1, wx;
        int          count;
        t_out_pixel  op;
        w     = fit_size(width_reg);
        h     = fit_size(height_reg);
        col   = (src_col >= w) ? 0 : src_col;
        row   = (src_row >= h) ? 0 : src_row;
        count = 0;
        if (col == 0) begin
            if (row > 0)
                for (int k = 0; k < MAX_SOURCE_WIDTH; k++) line_above[k] = line_now[k];
            rows_open    = 0;
            out_col_next = 0;
            for (int unsigned y = 0; y < OUT_HEIGHT; y++) begin
                map_coord(y, h, OUT_HEIGHT, a0, a1, wt);
                if (a1 == row) begin
                    if (!rows_open) row_first = y;
                    row_last  = y;
                    rows_open = 1;
                end
            end
        end
        line_now[col] = px;
        x_end = out_col_next;
        while (x_end < OUT_WIDTH) begin
            map_coord(x_end, w, OUT_WIDTH, a0, a1, wt);
            if (a1 != col) break;
            x_end++;
        end
        if (rows_open) begin
            for (int unsigned y = row_first; y <= row_last; y++) begin
                map_coord(y, h, OUT_HEIGHT, y0, y1, wy);
                for (int unsigned x = out_col_next; x < x_end; x++) begin
                    logic [RGB_W-1:0] tl, tr, bl, br;
                    if (count >= MAX_RESULTS) break;
                    map_coord(x, w, OUT_WIDTH, x0, x1, wx);
                    tl = (y0 == row) ? line_now[x0] : line_above[x0];
                    tr = (y0 == row) ? line_now[x1] : line_above[x1];
                    bl = line_now[x0];
                    br = line_now[x1];
                    op.x     = x[COORD_W-1:0];
                    op.y     = y[COORD_W-1:0];
                    op.red   = norm_channel(chan_of(tl, 0), chan_of(tr, 0), chan_of(bl, 0),
                                            chan_of(br, 0), wx, wy, 0);
                    op.green = norm_channel(chan_of(tl, 1), chan_of(tr, 1), chan_of(bl, 1),
                                            chan_of(br, 1), wx, wy, 1);
                    op.blue  = norm_channel(chan_of(tl, 2), chan_of(tr, 2), chan_of(bl, 2),
                                            chan_of(br, 2), wx, wy, 2);
                    op.run_last  = 1'b0;
                    op.frame_end = (x == OUT_WIDTH - 1 && y == OUT_HEIGHT - 1);
                    scaled_q.insert(scaled_q.size(), op);
                    count++;
                end
            end
        end
        if (count > 0) scaled_q[scaled_q.size() - 1].run_last = 1'b1;
        out_col_next = x_end;
        col++;
        if (col >= w) begin
            col = 0;
            row++;
            if (row >= h) row = 0;
        end
        src_col = col;
        src_row = row;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t ns: result mismatch on %s: got %0d, expected %0d",
                 $realtime, what, got, want);
        o_fail_count++;
    endtask

    initial o_fail_count = 0;

    always @(posedge i_clk) begin
        t_out_pixel want;
        if (!i_rst_n) begin
            scaled_q.delete();
            for (int k = 0; k < MAX_SOURCE_WIDTH; k++) begin
                line_above[k] = '0;
                line_now[k]   = '0;
            end
            width_reg     = RST_SOURCE_WIDTH;
            height_reg    = RST_SOURCE_HEIGHT;
            gain_reg[0]   = RST_GAIN_RED;
            gain_reg[1]   = RST_GAIN_GREEN;
            gain_reg[2]   = RST_GAIN_BLUE;
            offset_reg[0] = RST_OFFSET_RED;
            offset_reg[1] = RST_OFFSET_GREEN;
            offset_reg[2] = RST_OFFSET_BLUE;
            restart_frame();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SOURCE_WIDTH: begin
                        width_reg = i_cfg_data[SIZE_W-1:0];
                        restart_frame();
                    end
                    CFG_SOURCE_HEIGHT: begin
                        height_reg = i_cfg_data[SIZE_W-1:0];
                        restart_frame();
                    end
                    CFG_GAIN_RED:     gain_reg[0] = i_cfg_data;
                    CFG_GAIN_GREEN:   gain_reg[1] = i_cfg_data;
                    CFG_GAIN_BLUE:    gain_reg[2] = i_cfg_data;
                    CFG_OFFSET_RED:   offset_reg[0] = $signed(i_cfg_data[OFFS_W-1:0]);
                    CFG_OFFSET_GREEN: offset_reg[1] = $signed(i_cfg_data[OFFS_W-1:0]);
                    CFG_OFFSET_BLUE:  offset_reg[2] = $signed(i_cfg_data[OFFS_W-1:0]);
                    default: ;
                endcase
            end
            if (i_pix.valid && i_pix.ready)
                release_outputs({i_pix.red, i_pix.green, i_pix.blue});
            if (i_res.valid && i_res.ready) begin
                if (scaled_q.size() == 0) begin
                    $display("%0t ns: result transaction with no prediction outstanding",
                             $realtime);
                    o_fail_count++;
                end else begin
                    want = scaled_q.pop_front();
                    if (i_res.out_x != want.x)
                        report_mismatch("out_x", i_res.out_x, want.x);
                    if (i_res.out_y != want.y)
                        report_mismatch("out_y", i_res.out_y, want.y);
                    if (i_res.norm_red != want.red)
                        report_mismatch("norm_red", i_res.norm_red, want.red);
                    if (i_res.norm_green != want.green)
                        report_mismatch("norm_green", i_res.norm_green, want.green);
                    if (i_res.norm_blue != want.blue)
                        report_mismatch("norm_blue", i_res.norm_blue, want.blue);
                    if (i_res.run_last !== want.run_last)
                        report_mismatch("run_last", i_res.run_last, want.run_last);
                    if (i_res.frame_end !== want.frame_end)
                        report_mismatch("frame_end", i_res.frame_end, want.frame_end);
                end
            end
        end
        o_pending <= scaled_q.size();
    end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the bilinear resize and normalize block
// Streams directed and random source pixels through several register
// settings under random valid and ready gaps; the checker predicts and
// compares every output pixel.
// ----------------------------------------------------------------------------
module testbench;
    import brn_pkg::*;

    localparam int SETTLE_CYCLES = 3000;
    localparam int HOLD_CYCLES   = 400;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;
    int                    pixels_sent;
    bit                    hold_req;
    int                    hold_left;

    brn_pixel_if  pix_if ();
    brn_result_if res_if ();

    bilinear_resize_normalize i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (pix_if),
        .o_res      (res_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    brn_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pix        (pix_if),
        .i_res        (res_if),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // The idle mix changes with progress: receiver sparse first, then the
    // sender sparse, then both at full rate.
    function automatic int sender_idle_pct();
        if (pixels_sent < 160) return 36;
        if (pixels_sent < 320) return 63;
        return 0;
    endfunction

    function automatic int receiver_idle_pct();
        if (pixels_sent < 160) return 63;
        if (pixels_sent < 320) return 36;
        return 0;
    endfunction

    initial begin
        res_if.ready <= 1'b0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req  = 0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= ($urandom_range(99) >= receiver_idle_pct());
            end
        end
    end

    task automatic send_pixel(input logic [7:0] r, g, b);
        while ($urandom_range(99) < sender_idle_pct()) begin
            pix_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.red   <= r;
        pix_if.green <= g;
        pix_if.blue  <= b;
        @(posedge i_clk);
        while (!pix_if.ready) @(posedge i_clk);
        pixels_sent++;
    endtask

    // Waits until every predicted result has arrived, then optionally lets a
    // pixel that releases nothing finish its row scan.
    task automatic drain(input bit settle);
        pix_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        if (settle) repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_regs(input int unsigned w, h, gr, gg, gb,
                                input int orr, og, ob);
        int unsigned vals [8];
        vals = '{w, h, gr, gg, gb, orr & 16'hFFFF, og & 16'hFFFF, ob & 16'hFFFF};
        for (int k = 0; k < 8; k++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= k[CFG_IDX_W-1:0];
            cfg_data <= vals[k][CFG_DATA_W-1:0];
            @(posedge i_clk);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic random_pixels(input int n, input bit mid_pause, input bit long_hold);
        if (long_hold) hold_req = 1;
        for (int k = 0; k < n; k++) begin
            send_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255));
            if (mid_pause && k == n / 2) drain(1'b0);
        end
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_idx      <= '0;
        cfg_data     <= '0;
        pix_if.valid <= 1'b0;
        pix_if.red   <= '0;
        pix_if.green <= '0;
        pix_if.blue  <= '0;
        pixels_sent  = 0;
        hold_req     = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: the first source row releases nothing.
        send_pixel(8'h00, 8'h00, 8'h00);
        send_pixel(8'hFF, 8'hFF, 8'hFF);
        for (int k = 0; k < 8; k++) send_pixel(8'h01 << k, ~(8'h01 << k), 8'(k * 37));
        drain(1'b1);

        // Zero sizes count as one, so every pixel ends a frame and releases
        // the capped run of outputs; extreme gains and offsets saturate.
        program_regs(0, 0, 24'hFFFFFF, 0, 287306, 32767, -32768, 0);
        send_pixel(8'hFF, 8'hFF, 8'hFF);
        send_pixel(8'h00, 8'h00, 8'h00);
        send_pixel(8'hFF, 8'h00, 8'h80);
        send_pixel(8'h7F, 8'h80, 8'h01);
        drain(1'b1);
        program_regs(0, 0, 0, 24'hFFFFFF, 24'hFFFFFF, -32768, 32767, -1);
        send_pixel(8'hFF, 8'hFF, 8'hFF);
        send_pixel(8'h00, 8'h01, 8'hFE);
        drain(1'b1);

        program_regs(120, 120, $urandom_range(200000, 400000), $urandom_range(200000, 400000),
                     $urandom_range(200000, 400000), $urandom_range(0, 16383) - 8192,
                     $urandom_range(0, 16383) - 8192, $urandom_range(0, 16383) - 8192);
        random_pixels(170, 1'b1, 1'b0);
        drain(1'b1);

        // Sizes past the largest are clamped.
        program_regs(8191, 4096, 0, 0, 0, $urandom_range(0, 65535) - 32768,
                     $urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768);
        random_pixels(40, 1'b0, 1'b0);
        drain(1'b1);

        program_regs(2, 3, $urandom_range(0, 24'hFFFFFF), 287306, 293719,
                     -8675, -8338, -7391);
        random_pixels(100, 1'b0, 1'b1);
        drain(1'b1);

        program_regs(121, 2, 287306, 293719, 292413, -8675, -8338, -7391);
        random_pixels(160, 1'b0, 1'b0);
        drain(1'b1);

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/brn_pkg.sv
rtl/brn_pixel_if.sv
rtl/brn_result_if.sv
rtl/brn_coord_map.sv
rtl/brn_datapath.sv
rtl/brn_ctrl.sv
rtl/bilinear_resize_normalize.sv
tb/brn_checker.sv
tb/testbench.sv
